// ===== hw/rtl/extent_map_lookup_insert_unit_assert.svh =====
// assertion macros for the extent map unit
`ifndef EXTENT_MAP_LOOKUP_INSERT_UNIT_ASSERT_SVH
`define EXTENT_MAP_LOOKUP_INSERT_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define EMLI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("extent map check failed");

// consequent in the cycle after the antecedent
`define EMLI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("extent map check failed");

`endif

// ===== hw/rtl/emli_pkg.sv =====
package emli_pkg;

	localparam int MAX_EXTENTS_DEF = 64;
	localparam int LW = 54;
	localparam int PW = 52;
	localparam int NW = 21;
	localparam int RW = 32;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [LW-1:0] ls;
		logic [PW-1:0] ps;
		logic [RW-1:0] len;
		logic          uw;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PROBE,
		OP_STEP,
		OP_RD_LO,
		OP_RD_PREV,
		OP_WR_LEFT,
		OP_WR_RIGHT,
		OP_SHIFT_INIT,
		OP_SHIFT_RD,
		OP_SHIFT_WR,
		OP_PLACE,
		OP_RES_HIT,
		OP_RES_HOLE,
		OP_RES_UNB,
		OP_RES_OK,
		OP_RES_FULL,
		OP_RES_OVF
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_ins;
		logic zero_len;
		logic done;
		logic lo_lt_count;
		logic at_gt0;
		logic hit;
		logic match_left;
		logic match_right;
		logic len_ovf;
		logic full;
		logic shift_more;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_HIT,
		S_MISS,
		S_UNB,
		S_LEFT,
		S_RIGHT,
		S_PLACE_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_OK,
		S_FULL,
		S_OVF
	} state_t;

endpackage

// ===== hw/rtl/emli_ctrl.sv =====
module emli_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  emli_pkg::dp_sts_t sts,
	output emli_pkg::dp_cmd_t cmd
);
	import emli_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.is_ins && sts.zero_len) begin
					state_d = S_OK;
				end else if (!sts.done) begin
					cmd.op  = OP_PROBE;
					state_d = S_CMP;
				end else if (!sts.is_ins) begin
					if (sts.lo_lt_count) begin
						cmd.op  = OP_RD_LO;
						state_d = S_MISS;
					end else begin
						state_d = S_UNB;
					end
				end else if (sts.at_gt0) begin
					cmd.op  = OP_RD_PREV;
					state_d = S_LEFT;
				end else if (sts.lo_lt_count) begin
					cmd.op  = OP_RD_LO;
					state_d = S_RIGHT;
				end else begin
					state_d = S_PLACE_CHK;
				end
			end
			S_CMP: begin
				cmd.op = OP_STEP;
				if (!sts.is_ins && sts.hit) begin
					state_d = S_HIT;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_LEFT: begin
				if (sts.match_left) begin
					if (sts.len_ovf) begin
						state_d = S_OVF;
					end else begin
						cmd.op  = OP_WR_LEFT;
						state_d = S_OK;
					end
				end else if (sts.lo_lt_count) begin
					cmd.op  = OP_RD_LO;
					state_d = S_RIGHT;
				end else begin
					state_d = S_PLACE_CHK;
				end
			end
			S_RIGHT: begin
				if (sts.match_right) begin
					if (sts.len_ovf) begin
						state_d = S_OVF;
					end else begin
						cmd.op  = OP_WR_RIGHT;
						state_d = S_OK;
					end
				end else begin
					state_d = S_PLACE_CHK;
				end
			end
			S_PLACE_CHK: begin
				if (sts.full) begin
					state_d = S_FULL;
				end else begin
					cmd.op  = OP_SHIFT_INIT;
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (sts.shift_more) begin
					cmd.op  = OP_SHIFT_RD;
					state_d = S_SHIFT_WR;
				end else begin
					cmd.op  = OP_PLACE;
					state_d = S_OK;
				end
			end
			S_SHIFT_WR: begin
				cmd.op  = OP_SHIFT_WR;
				state_d = S_SHIFT_RD;
			end
			S_HIT: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_HIT;
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_HOLE;
					state_d = S_IDLE;
				end
			end
			S_UNB: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_UNB;
					state_d = S_IDLE;
				end
			end
			S_OK: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_OK;
					state_d = S_IDLE;
				end
			end
			S_FULL: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_FULL;
					state_d = S_IDLE;
				end
			end
			S_OVF: begin
				if (sts.out_free) begin
					cmd.op  = OP_RES_OVF;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/emli_dp.sv =====
module emli_dp #(
	parameter int MaxExtents = emli_pkg::MAX_EXTENTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  emli_pkg::dp_cmd_t       cmd,
	output emli_pkg::dp_sts_t       sts,
	input  logic                    cmd_in,
	input  logic [emli_pkg::LW-1:0] logical_block,
	input  logic [emli_pkg::PW-1:0] phys_start,
	input  logic [emli_pkg::NW-1:0] block_count,
	input  logic                    unwritten_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic                    is_hole,
	output logic                    hole_unbounded,
	output logic [emli_pkg::PW-1:0] phys_block,
	output logic [emli_pkg::RW-1:0] run_length,
	output logic                    unwritten_out
);
	import emli_pkg::*;

	localparam int AW = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;
	localparam int CW = $clog2(MaxExtents + 1);
	localparam int SW = CW + 1;

	entry_t mem [MaxExtents];
	entry_t rd_q;

	logic                 cmd_q;
	logic [LW-1:0]        blk_q;
	logic [PW-1:0]        ps_q;
	logic [NW-1:0]        n_q;
	logic                 uw_q;
	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] lo_q, hi_q;
	logic [AW-1:0]        mid_q;
	logic [CW-1:0]        idx_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic                 is_hole_q, unb_q, uw_out_q;
	logic [PW-1:0]        phys_q;
	logic [RW-1:0]        run_q;

	logic signed [SW:0]   mid_sum;
	logic [AW-1:0]        mid_w;
	logic signed [SW-1:0] mid_ext, count_ext, idx_ext, lo_m1;
	logic [AW-1:0]        lo_idx, prev_idx, idx_m1;
	logic [RW:0]          sum_len;
	logic [LW:0]          end_log;
	logic [LW:0]          new_end_log;
	logic [PW:0]          end_phys, new_end_phys;
	logic                 below, above;
	logic [LW-1:0]        off;
	logic [LW:0]          gap;
	logic                 out_free;
	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;
	entry_t               wr_data;

	assign mid_sum   = (SW+1)'(lo_q) + (SW+1)'(hi_q);
	assign mid_w     = mid_sum[AW:1];
	assign mid_ext   = SW'({1'b0, mid_q});
	assign count_ext = SW'({1'b0, count_q});
	assign idx_ext   = SW'({1'b0, idx_q});
	assign lo_m1     = lo_q - SW'(1);
	assign lo_idx    = lo_q[AW-1:0];
	assign prev_idx  = lo_m1[AW-1:0];
	assign idx_m1    = AW'(idx_q - CW'(1));

	assign sum_len      = {1'b0, rd_q.len} + (RW+1)'(n_q);
	assign end_log      = {1'b0, rd_q.ls} + (LW+1)'(rd_q.len);
	assign end_phys     = {1'b0, rd_q.ps} + (PW+1)'(rd_q.len);
	assign new_end_log  = {1'b0, blk_q} + (LW+1)'(n_q);
	assign new_end_phys = {1'b0, ps_q} + (PW+1)'(n_q);
	assign below        = blk_q < rd_q.ls;
	assign above        = {1'b0, blk_q} >= end_log;
	assign off          = blk_q - rd_q.ls;
	assign gap          = {1'b0, rd_q.ls} - {1'b0, blk_q};
	assign out_free     = !out_valid_q || out_ready;

	always_comb begin
		sts.is_ins      = cmd_q;
		sts.zero_len    = (n_q == '0);
		sts.done        = cmd_q ? (lo_q >= hi_q) : (lo_q > hi_q);
		sts.lo_lt_count = lo_q < count_ext;
		sts.at_gt0      = lo_q > SW'(0);
		sts.hit         = !below && !above;
		sts.match_left  = (end_log == {1'b0, blk_q}) && (end_phys == {1'b0, ps_q})
			&& (rd_q.uw == uw_q);
		sts.match_right = (new_end_log == {1'b0, rd_q.ls})
			&& (new_end_phys == {1'b0, rd_q.ps}) && (rd_q.uw == uw_q);
		sts.len_ovf     = sum_len[RW];
		sts.full        = (count_q == CW'(MaxExtents));
		sts.shift_more  = idx_ext > lo_q;
		sts.out_free    = out_free;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = lo_idx;
		wr_en   = 1'b0;
		wr_addr = lo_idx;
		wr_data = '{ls: blk_q, ps: ps_q, len: RW'(n_q), uw: uw_q};
		case (cmd.op)
			OP_PROBE: begin
				rd_en   = 1'b1;
				rd_addr = mid_w;
			end
			OP_RD_LO: begin
				rd_en = 1'b1;
			end
			OP_RD_PREV: begin
				rd_en   = 1'b1;
				rd_addr = prev_idx;
			end
			OP_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_m1;
			end
			OP_WR_LEFT: begin
				wr_en   = 1'b1;
				wr_addr = prev_idx;
				wr_data = '{ls: rd_q.ls, ps: rd_q.ps, len: sum_len[RW-1:0], uw: rd_q.uw};
			end
			OP_WR_RIGHT: begin
				wr_en   = 1'b1;
				wr_data = '{ls: blk_q, ps: ps_q, len: sum_len[RW-1:0], uw: uw_q};
			end
			OP_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_q;
			end
			OP_PLACE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cmd_q <= cmd_in;
				blk_q <= logical_block;
				ps_q  <= phys_start;
				n_q   <= block_count;
				uw_q  <= unwritten_in;
				lo_q  <= '0;
				hi_q  <= cmd_in ? count_ext : count_ext - SW'(1);
			end
			OP_PROBE: begin
				mid_q <= mid_w;
			end
			OP_STEP: begin
				if (cmd_q) begin
					if (rd_q.ls < blk_q) begin
						lo_q <= mid_ext + SW'(1);
					end else begin
						hi_q <= mid_ext;
					end
				end else if (below) begin
					hi_q <= mid_ext - SW'(1);
				end else if (above) begin
					lo_q <= mid_ext + SW'(1);
				end
			end
			OP_SHIFT_INIT: begin
				idx_q <= count_q;
			end
			OP_SHIFT_WR: begin
				idx_q <= idx_q - CW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RES_HIT: begin
				status_q  <= ST_OK;
				is_hole_q <= 1'b0;
				unb_q     <= 1'b0;
				phys_q    <= rd_q.ps + off[PW-1:0];
				run_q     <= rd_q.len - off[RW-1:0];
				uw_out_q  <= rd_q.uw;
			end
			OP_RES_HOLE: begin
				status_q  <= ST_OK;
				is_hole_q <= 1'b1;
				unb_q     <= 1'b0;
				phys_q    <= '0;
				run_q     <= (gap[LW:RW] != '0) ? '1 : gap[RW-1:0];
				uw_out_q  <= 1'b0;
			end
			OP_RES_UNB: begin
				status_q  <= ST_OK;
				is_hole_q <= 1'b1;
				unb_q     <= 1'b1;
				phys_q    <= '0;
				run_q     <= '1;
				uw_out_q  <= 1'b0;
			end
			OP_RES_OK, OP_RES_FULL, OP_RES_OVF: begin
				status_q  <= (cmd.op == OP_RES_FULL) ? ST_FULL :
					(cmd.op == OP_RES_OVF) ? ST_OVF : ST_OK;
				is_hole_q <= 1'b0;
				unb_q     <= 1'b0;
				phys_q    <= '0;
				run_q     <= '0;
				uw_out_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_PLACE) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.op == OP_RES_HIT || cmd.op == OP_RES_HOLE || cmd.op == OP_RES_UNB
				|| cmd.op == OP_RES_OK || cmd.op == OP_RES_FULL
				|| cmd.op == OP_RES_OVF) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign is_hole        = is_hole_q;
	assign hole_unbounded = unb_q;
	assign phys_block     = phys_q;
	assign run_length     = run_q;
	assign unwritten_out  = uw_out_q;

endmodule

// ===== hw/rtl/extent_map_lookup_insert_unit.sv =====
// Extent map with lookup and insert, sorted by logical start.
// Input channel in_valid/in_ready carries one item: cmd, logical_block,
// phys_start, block_count, unwritten_in. cmd 0 looks up a block, cmd 1
// inserts an extent. Output channel out_valid/out_ready returns one result
// item per input item, in order.
// A lookup binary-searches the table through the single registered read
// port of the extent memory, each probe a read and then a compare, at most
// ceil(log2(n+1)) probes, then forms the result; a bounded miss first reads
// the next entry to size the hole.
// An insert runs a lower-bound search for its position (ceil(log2(n+1))
// probes) and reads up to two neighbors; a plain insert shifts later
// entries up one at a time, each a read and then a write.
// One item is in work at a time; in_ready is high only while idle.
// Reset empties the table at once (entry count to zero), no clearing pass.
// If the receiver stalls, the result waits in the output register and the
// next item is still taken; that item waits at its end until the register
// frees.
module extent_map_lookup_insert_unit #(
	parameter int MaxExtents = emli_pkg::MAX_EXTENTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [emli_pkg::LW-1:0] logical_block,
	input  logic [emli_pkg::PW-1:0] phys_start,
	input  logic [emli_pkg::NW-1:0] block_count,
	input  logic                    unwritten_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic                    is_hole,
	output logic                    hole_unbounded,
	output logic [emli_pkg::PW-1:0] phys_block,
	output logic [emli_pkg::RW-1:0] run_length,
	output logic                    unwritten_out
);
	import emli_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	emli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dsts),
		.cmd      (dcmd)
	);

	emli_dp #(
		.MaxExtents (MaxExtents)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dcmd),
		.sts            (dsts),
		.cmd_in         (cmd),
		.logical_block  (logical_block),
		.phys_start     (phys_start),
		.block_count    (block_count),
		.unwritten_in   (unwritten_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.is_hole        (is_hole),
		.hole_unbounded (hole_unbounded),
		.phys_block     (phys_block),
		.run_length     (run_length),
		.unwritten_out  (unwritten_out)
	);

`include "extent_map_lookup_insert_unit_assert.svh"

	`EMLI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`EMLI_ASSERT_NOW(a_result_at_idle, $rose(out_valid), in_ready)
	`EMLI_ASSERT_NOW(a_hole_fields, out_valid && is_hole,
		status == ST_OK && phys_block == '0 && unwritten_out == 1'b0)
	`EMLI_ASSERT_NOW(a_unbounded_run, out_valid && hole_unbounded,
		is_hole && run_length == '1)

endmodule

// ===== tb/extent_map_tb_pkg.sv =====
package extent_map_tb_pkg;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;

endpackage

// ===== tb/extent_map_lookup_insert_checker.sv =====
module extent_map_lookup_insert_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic                    cmd,
	input  logic [emli_pkg::LW-1:0] logical_block,
	input  logic [emli_pkg::PW-1:0] phys_start,
	input  logic [emli_pkg::NW-1:0] block_count,
	input  logic                    unwritten_in,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [1:0]              status,
	input  logic                    is_hole,
	input  logic                    hole_unbounded,
	input  logic [emli_pkg::PW-1:0] phys_block,
	input  logic [emli_pkg::RW-1:0] run_length,
	input  logic                    unwritten_out,
	output int                      failures,
	output int                      pending
);
	import emli_pkg::*;
	import extent_map_tb_pkg::*;

	localparam int DEPTH = MAX_EXTENTS_DEF;

	typedef struct packed {
		logic [1:0]    st;
		logic          hole;
		logic          unb;
		logic [PW-1:0] phys;
		logic [RW-1:0] run;
		logic          uw;
	} mapping_t;

	logic [LW-1:0] map_ls[DEPTH];
	logic [PW-1:0] map_ps[DEPTH];
	logic [RW-1:0] map_len[DEPTH];
	logic          map_uw[DEPTH];
	int            map_cnt;
	mapping_t      expected_q[$];
	int            errs;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errs++;
	endtask

	function automatic mapping_t find_block(input logic [LW-1:0] blk);
		mapping_t r;
		int lo, hi, mid, hit;
		logic [63:0] off, d;
		r = '0;
		lo = 0;
		hi = map_cnt - 1;
		hit = -1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (64'(blk) < 64'(map_ls[mid]))
				hi = mid - 1;
			else if (64'(blk) >= 64'(map_ls[mid]) + 64'(map_len[mid]))
				lo = mid + 1;
			else begin
				hit = mid;
				break;
			end
		end
		if (hit >= 0) begin
			off = 64'(blk) - 64'(map_ls[hit]);
			r.phys = PW'(64'(map_ps[hit]) + off);
			r.run = RW'(64'(map_len[hit]) - off);
			r.uw = map_uw[hit];
		end else begin
			r.hole = 1'b1;
			if (lo < map_cnt) begin
				d = 64'(map_ls[lo]) - 64'(blk);
				r.run = (d > LEN_MAX) ? RW'(LEN_MAX) : RW'(d);
			end else begin
				r.unb = 1'b1;
				r.run = RW'(LEN_MAX);
			end
		end
		return r;
	endfunction

	function automatic logic [1:0] add_extent(input logic [LW-1:0] ls, input logic [PW-1:0] ps,
			input logic [NW-1:0] n, input logic uw);
		int at, p;
		if (n == 0)
			return ST_OK;
		at = 0;
		while (at < map_cnt && map_ls[at] < ls)
			at++;
		if (at > 0) begin
			p = at - 1;
			if (64'(map_ls[p]) + 64'(map_len[p]) == 64'(ls) &&
					64'(map_ps[p]) + 64'(map_len[p]) == 64'(ps) && map_uw[p] == uw) begin
				if (64'(map_len[p]) + 64'(n) > LEN_MAX)
					return ST_OVF;
				map_len[p] = map_len[p] + RW'(n);
				return ST_OK;
			end
		end
		if (at < map_cnt) begin
			if (64'(ls) + 64'(n) == 64'(map_ls[at]) &&
					64'(ps) + 64'(n) == 64'(map_ps[at]) && map_uw[at] == uw) begin
				if (64'(map_len[at]) + 64'(n) > LEN_MAX)
					return ST_OVF;
				map_ls[at] = ls;
				map_ps[at] = ps;
				map_len[at] = map_len[at] + RW'(n);
				return ST_OK;
			end
		end
		if (map_cnt >= DEPTH)
			return ST_FULL;
		for (int i = map_cnt; i > at; i--) begin
			map_ls[i] = map_ls[i-1];
			map_ps[i] = map_ps[i-1];
			map_len[i] = map_len[i-1];
			map_uw[i] = map_uw[i-1];
		end
		map_ls[at] = ls;
		map_ps[at] = ps;
		map_len[at] = RW'(n);
		map_uw[at] = uw;
		map_cnt++;
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mapping_t e;
		if (!arst_n) begin
			map_cnt = 0;
			expected_q.delete();
			errs = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0)
					report("unexpected item", 64'(status), 64'hx);
				else begin
					e = expected_q.pop_front();
					if (status !== e.st) report("status", 64'(status), 64'(e.st));
					if (is_hole !== e.hole) report("is_hole", 64'(is_hole), 64'(e.hole));
					if (hole_unbounded !== e.unb)
						report("hole_unbounded", 64'(hole_unbounded), 64'(e.unb));
					if (phys_block !== e.phys) report("phys_block", 64'(phys_block), 64'(e.phys));
					if (run_length !== e.run) report("run_length", 64'(run_length), 64'(e.run));
					if (unwritten_out !== e.uw)
						report("unwritten_out", 64'(unwritten_out), 64'(e.uw));
				end
			end
			if (in_valid && in_ready) begin
				if (cmd == CMD_LOOKUP)
					e = find_block(logical_block);
				else begin
					e = '0;
					e.st = add_extent(logical_block, phys_start, block_count, unwritten_in);
				end
				expected_q.push_back(e);
			end
			failures <= errs;
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/extent_map_lookup_insert_unit_test.sv =====
module extent_map_lookup_insert_unit_test;
	import emli_pkg::*;
	import extent_map_tb_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam logic [LW-1:0] L_MAX = '1;
	localparam logic [PW-1:0] P_MAX = '1;
	localparam logic [NW-1:0] N_MAX = '1;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          cmd;
	logic [LW-1:0] logical_block;
	logic [PW-1:0] phys_start;
	logic [NW-1:0] block_count;
	logic          unwritten_in;
	logic          out_valid;
	logic          out_ready;
	logic [1:0]    status;
	logic          is_hole;
	logic          hole_unbounded;
	logic [PW-1:0] phys_block;
	logic [RW-1:0] run_length;
	logic          unwritten_out;
	int            failures;
	int            pending;
	bit            calm;
	int            quiet_cycles = 0;

	extent_map_lookup_insert_unit i_dut (.*);

	extent_map_lookup_insert_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic offer(input logic c, input logic [LW-1:0] lb, input logic [PW-1:0] ps,
			input logic [NW-1:0] n, input logic uw);
		if (!calm)
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		cmd <= c;
		logical_block <= lb;
		phys_start <= ps;
		block_count <= n;
		unwritten_in <= uw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off, one calm stretch
	initial begin
		int cyc;
		cyc = 0;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			cyc++;
			if (cyc >= 2000 && cyc < 2400)
				out_ready <= 1'b0;
			else if (cyc >= 2600 && cyc < 4000)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 16);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		logic [63:0] r64;
		logic [LW-1:0] last_ls, ls;
		logic [PW-1:0] last_ps, ps;
		logic [NW-1:0] last_n, n;
		logic last_uw, uw, c, wide;
		int r;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOOKUP;
		logical_block = '0;
		phys_start = '0;
		block_count = '0;
		unwritten_in = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		offer(CMD_LOOKUP, 54'd5, '0, '0, 1'b0);
		offer(CMD_INSERT, 54'd1000, P_MAX - 52'd10, 21'd100, 1'b1);
		offer(CMD_LOOKUP, 54'd1050, P_MAX, N_MAX, 1'b1);
		offer(CMD_LOOKUP, 54'd0, '0, '0, 1'b0);
		offer(CMD_LOOKUP, 54'd2000, '0, '0, 1'b0);
		offer(CMD_INSERT, 54'd3000, 52'd7, 21'd0, 1'b0);
		offer(CMD_LOOKUP, 54'd3000, '0, '0, 1'b0);
		offer(CMD_INSERT, 54'd1100, 52'd89, 21'd10, 1'b1);
		offer(CMD_INSERT, 54'd1 << 40, 52'd1 << 30, 21'd100, 1'b0);
		offer(CMD_LOOKUP, 54'd1200, '0, '0, 1'b0);
		offer(CMD_INSERT, (54'd1 << 40) - 54'd50, (52'd1 << 30) - 52'd50, 21'd50, 1'b0);
		offer(CMD_INSERT, (54'd1 << 40) + 54'd100, (52'd1 << 30) + 52'd100, 21'd5, 1'b1);
		offer(CMD_INSERT, 54'd1110, 52'd99, 21'd5, 1'b1);
		offer(CMD_INSERT, L_MAX, P_MAX, 21'd1, 1'b0);
		offer(CMD_LOOKUP, L_MAX, '0, '0, 1'b0);
		offer(CMD_LOOKUP, (54'd1 << 40) - 54'd20, '0, '0, 1'b0);
		offer(CMD_LOOKUP, 54'd1112, '0, '0, 1'b0);

		// random
		last_ls = 54'd100;
		last_ps = 52'd500;
		last_n = 21'd4;
		last_uw = 1'b0;
		for (int i = 0; i < 533; i++) begin
			calm = (i >= 250 && i < 370);
			r = $urandom_range(99);
			wide = ($urandom_range(9) == 0);
			c = 1'($urandom_range(1));
			r64 = {$urandom, $urandom};
			ls = LW'(r64);
			r64 = {$urandom, $urandom};
			ps = PW'(r64);
			n = NW'($urandom);
			uw = 1'($urandom_range(1));
			if (c == CMD_INSERT) begin
				if (!wide) begin
					n = NW'($urandom_range(16, 1));
					if (r < 40) begin
						ls = last_ls + LW'(last_n);
						ps = last_ps + PW'(last_n);
						uw = ($urandom_range(9) == 0) ? !last_uw : last_uw;
					end else if (r < 55) begin
						ls = last_ls - LW'(n);
						ps = last_ps - PW'(n);
						uw = last_uw;
					end else begin
						ls = LW'($urandom_range(4095));
						ps = PW'($urandom_range(65535));
					end
					if (r == 99)
						n = '0;
				end
				last_ls = ls;
				last_ps = ps;
				last_n = n;
				last_uw = uw;
			end else if (!wide)
				ls = LW'($urandom_range(4200));
			offer(c, ls, ps, n, uw);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
